// ----- hdl/ledf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip formatter package
// Shared codes, command and result types for the pixel frame formatter.
// ----------------------------------------------------------------------------
package ledf_pkg;

	localparam int MaxPixels = 64;
	localparam int AddrW     = 6;
	localparam int CountW    = 7;
	localparam int QDepth    = 2;

	localparam logic [CountW-1:0] MAX_LEN = CountW'(MaxPixels);

	// request modes
	localparam logic [2:0] MODE_WRITE = 3'd0;
	localparam logic [2:0] MODE_READ  = 3'd1;
	localparam logic [2:0] MODE_CLEAR = 3'd2;
	localparam logic [2:0] MODE_FLUSH = 3'd3;
	localparam logic [2:0] MODE_DONE  = 3'd4;

	// chip types
	localparam logic [1:0] CHIP_GRB  = 2'd0;
	localparam logic [1:0] CHIP_GRBW = 2'd1;
	localparam logic [1:0] CHIP_WRGB = 2'd2;
	localparam logic [1:0] CHIP_DOT  = 2'd3;

	// result status
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_BUSY  = 2'd2;
	localparam logic [1:0] ST_IDLE  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_CHIP  = 2'd0;
	localparam logic [1:0] REG_COUNT = 2'd1;
	localparam logic [1:0] REG_QUIET = 2'd2;

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_READ,
		OP_CLEAR,
		OP_FLUSH,
		OP_DONE,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DATA,
		B_FRD,
		B_FCAP
	} back_state_t;

	typedef struct packed {
		op_t              op;
		logic             oor;
		logic [AddrW-1:0] index;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [7:0]       white;
		logic [31:0]      time_now;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic       changed;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic [7:0] third_byte;
		logic [7:0] fourth_byte;
		logic [2:0] byte_count;
		logic       last_of_frame;
	} res_t;

	function automatic logic [CountW-1:0] live_len(input logic [CountW-1:0] pc);
		logic [CountW-1:0] n;
		n = pc;
		if (n == '0)
			n = CountW'(1);
		if (n > MAX_LEN)
			n = MAX_LEN;
		return n;
	endfunction

endpackage

// ----- hdl/ledf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip formatter channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ledf_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [5:0]  index;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  white;
	logic [31:0] time_now;

	modport source(output valid, mode, index, red, green, blue, white, time_now,
		input ready);
	modport sink(input valid, mode, index, red, green, blue, white, time_now,
		output ready);
endinterface

interface ledf_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       changed;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic [7:0] third_byte;
	logic [7:0] fourth_byte;
	logic [2:0] byte_count;
	logic       last_of_frame;

	modport source(output valid, status, changed, first_byte, second_byte, third_byte,
		fourth_byte, byte_count, last_of_frame, input ready);
	modport sink(input valid, status, changed, first_byte, second_byte, third_byte,
		fourth_byte, byte_count, last_of_frame, output ready);
endinterface

// ----- hdl/ledf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip formatter front end
// Accepts requests, decodes the mode and checks the pixel index range.
// ----------------------------------------------------------------------------
module ledf_front import ledf_pkg::*; (
	ledf_item_if.sink         items,
	input  logic              full,
	input  logic [CountW-1:0] len,
	output logic              push,
	output cmd_t              cmd
);

	op_t  op;
	logic pix_op;

	assign items.ready = !full;
	assign push        = items.valid && !full;

	always_comb begin
		case (items.mode)
			MODE_WRITE: op = OP_WRITE;
			MODE_READ:  op = OP_READ;
			MODE_CLEAR: op = OP_CLEAR;
			MODE_FLUSH: op = OP_FLUSH;
			MODE_DONE:  op = OP_DONE;
			default:    op = OP_NOP;
		endcase
	end

	assign pix_op = (items.mode == MODE_WRITE) || (items.mode == MODE_READ);

	always_comb begin
		cmd          = '0;
		cmd.op       = op;
		cmd.oor      = pix_op && ({1'b0, items.index} >= len);
		cmd.index    = items.index;
		cmd.red      = items.red;
		cmd.green    = items.green;
		cmd.blue     = items.blue;
		cmd.white    = items.white;
		cmd.time_now = items.time_now;
	end

endmodule

// ----- hdl/ledf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip formatter command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ledf_queue import ledf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic head_vld
);

	localparam int PtrW = $clog2(QDepth);

	cmd_t              slot_q [QDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [PtrW:0]     cnt_q;

	assign full     = cnt_q == (PtrW + 1)'(QDepth);
	assign head_vld = cnt_q != '0;
	assign head     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (PtrW + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (PtrW + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- hdl/ledf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip formatter back end
// Executes queued requests against the pixel store and walks it on flush.
// ----------------------------------------------------------------------------
module ledf_back import ledf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              head,
	input  logic              head_vld,
	output logic              pop,
	input  logic [1:0]        chip_type,
	input  logic [CountW-1:0] len,
	input  logic [31:0]       quiescent_limit,
	ledf_result_if.source     results
);

	back_state_t state_q, state_d;

	logic [31:0]        mem [MaxPixels];
	logic [31:0]        rdata_q;
	logic [AddrW-1:0]   raddr_q;
	logic [MaxPixels-1:0] valid_q;
	logic [MaxPixels-1:0] nz_q;

	logic               dirty_q;
	logic               busy_q;
	logic [31:0]        last_time_q;

	logic [CountW-1:0]  ptr_q;
	logic [1:0]         dsel_q;
	logic [7:0]         dot0_q;
	logic [7:0]         dot1_q;

	logic               ovld_q;
	res_t               ores_q;

	logic [31:0]        entry;
	logic [31:0]        new_entry;
	logic [31:0]        elapsed;
	logic [7:0]         dot;
	logic [7:0]         on;
	logic               can_load;
	logic               quiet;
	logic               in_rng;
	logic               last_word;
	logic               word_done;

	logic               mem_re;
	logic [AddrW-1:0]   mem_raddr;
	logic               mem_we;
	logic               ld;
	res_t               res;
	logic               clr_all;
	logic               clr_busy;
	logic               flush_end;
	logic               ptr_rst;
	logic               ptr_inc;
	logic               dot_cap;
	logic               dsel_clr;

	assign entry     = valid_q[raddr_q] ? rdata_q : '0;
	assign can_load  = !ovld_q || results.ready;
	assign elapsed   = head.time_now - last_time_q;
	assign quiet     = !dirty_q && (elapsed < quiescent_limit);
	assign in_rng    = ptr_q < len;
	assign dot       = in_rng ? entry[7:0] : 8'd0;
	assign last_word = (ptr_q + CountW'(1)) >= len;
	assign word_done = (chip_type != CHIP_DOT) || (dsel_q == 2'd2);
	assign on        = ((head.red | head.green | head.blue | head.white) != 8'd0) ? 8'hFF : 8'h00;

	always_comb begin
		case (chip_type)
			CHIP_DOT: new_entry = {entry[31:8], on};
			CHIP_GRB: new_entry = {entry[31:24], head.blue, head.green, head.red};
			default:  new_entry = {head.white, head.blue, head.green, head.red};
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (head_vld) begin
					case (head.op)
						OP_WRITE, OP_READ: begin
							if (!head.oor)
								state_d = B_DATA;
						end
						OP_FLUSH: begin
							if (!busy_q && !quiet)
								state_d = B_FRD;
						end
						default: state_d = B_IDLE;
					endcase
				end
			end
			B_DATA: begin
				if (can_load)
					state_d = B_IDLE;
			end
			B_FRD: state_d = B_FCAP;
			B_FCAP: begin
				if (!word_done)
					state_d = B_FRD;
				else if (can_load)
					state_d = last_word ? B_IDLE : B_FRD;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mem_re            = 1'b0;
		mem_raddr         = head.index;
		mem_we            = 1'b0;
		ld                = 1'b0;
		pop               = 1'b0;
		clr_all           = 1'b0;
		clr_busy          = 1'b0;
		flush_end         = 1'b0;
		ptr_rst           = 1'b0;
		ptr_inc           = 1'b0;
		dot_cap           = 1'b0;
		dsel_clr          = 1'b0;
		res               = '0;
		res.status        = ST_OK;
		res.last_of_frame = 1'b1;
		case (state_q)
			B_IDLE: begin
				if (head_vld) begin
					case (head.op)
						OP_WRITE, OP_READ: begin
							if (head.oor) begin
								ld         = can_load;
								pop        = can_load;
								res.status = ST_RANGE;
							end else begin
								mem_re = 1'b1;
							end
						end
						OP_CLEAR: begin
							ld          = can_load;
							pop         = can_load;
							clr_all     = can_load;
							res.changed = |nz_q;
						end
						OP_FLUSH: begin
							if (busy_q) begin
								ld         = can_load;
								pop        = can_load;
								res.status = ST_BUSY;
							end else if (quiet) begin
								ld         = can_load;
								pop        = can_load;
								res.status = ST_IDLE;
							end else begin
								ptr_rst = 1'b1;
							end
						end
						OP_DONE: begin
							ld       = can_load;
							pop      = can_load;
							clr_busy = can_load;
						end
						default: begin
							ld  = can_load;
							pop = can_load;
						end
					endcase
				end
			end
			B_DATA: begin
				ld  = can_load;
				pop = can_load;
				if (head.op == OP_WRITE) begin
					mem_we      = can_load;
					res.changed = new_entry != entry;
				end else begin
					case (chip_type)
						CHIP_DOT: begin
							res.first_byte  = entry[7:0];
							res.second_byte = entry[7:0];
							res.third_byte  = entry[7:0];
						end
						CHIP_GRB: begin
							res.first_byte  = entry[7:0];
							res.second_byte = entry[15:8];
							res.third_byte  = entry[23:16];
						end
						default: begin
							res.first_byte  = entry[7:0];
							res.second_byte = entry[15:8];
							res.third_byte  = entry[23:16];
							res.fourth_byte = entry[31:24];
						end
					endcase
				end
			end
			B_FRD: begin
				mem_re    = 1'b1;
				mem_raddr = ptr_q[AddrW-1:0];
			end
			B_FCAP: begin
				if (!word_done) begin
					dot_cap = 1'b1;
					ptr_inc = 1'b1;
				end else begin
					ld                = can_load;
					res.last_of_frame = last_word;
					case (chip_type)
						CHIP_GRB: begin
							res.first_byte  = entry[15:8];
							res.second_byte = entry[7:0];
							res.third_byte  = entry[23:16];
							res.byte_count  = 3'd3;
						end
						CHIP_GRBW: begin
							res.first_byte  = entry[15:8];
							res.second_byte = entry[7:0];
							res.third_byte  = entry[23:16];
							res.fourth_byte = entry[31:24];
							res.byte_count  = 3'd4;
						end
						CHIP_WRGB: begin
							res.first_byte  = entry[31:24];
							res.second_byte = entry[7:0];
							res.third_byte  = entry[15:8];
							res.fourth_byte = entry[23:16];
							res.byte_count  = 3'd4;
						end
						default: begin
							res.first_byte  = dot0_q;
							res.second_byte = dot1_q;
							res.third_byte  = dot;
							res.byte_count  = 3'd3;
						end
					endcase
					if (can_load) begin
						if (last_word) begin
							pop       = 1'b1;
							flush_end = 1'b1;
						end else begin
							ptr_inc  = 1'b1;
							dsel_clr = 1'b1;
						end
					end
				end
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[raddr_q] <= new_entry;
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
			raddr_q <= mem_raddr;
		end
		if (dot_cap) begin
			if (dsel_q == 2'd0)
				dot0_q <= dot;
			else
				dot1_q <= dot;
		end
		if (ld)
			ores_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			valid_q     <= '0;
			nz_q        <= '0;
			dirty_q     <= 1'b0;
			busy_q      <= 1'b0;
			last_time_q <= '0;
			ptr_q       <= '0;
			dsel_q      <= '0;
			ovld_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_all) begin
				valid_q <= '0;
				nz_q    <= '0;
			end else if (mem_we) begin
				valid_q[raddr_q] <= 1'b1;
				nz_q[raddr_q]    <= new_entry != '0;
			end
			if (flush_end)
				dirty_q <= 1'b0;
			else if ((clr_all && (|nz_q)) || (mem_we && (new_entry != entry)))
				dirty_q <= 1'b1;
			if (flush_end) begin
				busy_q      <= 1'b1;
				last_time_q <= head.time_now;
			end else if (clr_busy) begin
				busy_q <= 1'b0;
			end
			if (ptr_rst)
				ptr_q <= '0;
			else if (ptr_inc)
				ptr_q <= ptr_q + CountW'(1);
			if (ptr_rst || dsel_clr)
				dsel_q <= '0;
			else if (dot_cap)
				dsel_q <= dsel_q + 2'd1;
			if (ld)
				ovld_q <= 1'b1;
			else if (results.ready)
				ovld_q <= 1'b0;
		end
	end

	assign results.valid         = ovld_q;
	assign results.status        = ores_q.status;
	assign results.changed       = ores_q.changed;
	assign results.first_byte    = ores_q.first_byte;
	assign results.second_byte   = ores_q.second_byte;
	assign results.third_byte    = ores_q.third_byte;
	assign results.fourth_byte   = ores_q.fourth_byte;
	assign results.byte_count    = ores_q.byte_count;
	assign results.last_of_frame = ores_q.last_of_frame;

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_vld)
		else $error("pop from empty queue");

	a_busy_on_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != B_IDLE) |-> head_vld)
		else $error("back end working without a queued request");

	a_write_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == B_DATA) && (head.op == OP_WRITE)))
		else $error("store written outside a pixel write");

	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		flush_end |=> (busy_q && !dirty_q && (state_q == B_IDLE)))
		else $error("flush end did not update frame state");

	a_dot_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_FCAP) |-> (dsel_q != 2'd3))
		else $error("dot selector overran");

endmodule

// ----- hdl/led_strip_pixel_frame_formatter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pixel frame formatter
// Pixel store and wire-order formatter for addressable LED strips.
// ----------------------------------------------------------------------------
// Requests arrive on items (valid/ready); each gives one or more results on
// results (valid/ready), the final one flagged by last_of_frame. Registers
// chip_type, pixel_count and quiescent_limit are written through cfg_wr_en,
// cfg_index and cfg_data; the user must write them only while no request is
// in flight; the block itself does not enforce this.
// A request enters a two-entry queue and is taken by the back end from its
// head. Write and read pass the idle state (store read), then the data state
// (update and result); clear, send done, refused flushes and out-of-range
// requests are answered from the idle state alone. A flush walks the store
// over its single read port, with a store read and a capture per LED word
// for GRB/GRBW/WRGB chips and three store reads per word for flip-dot panels.
// Results sit in an output register that the back end can refill as the
// receiver takes the waiting one; a stalled receiver holds the back end once
// that register is full, and the queue then fills and drops items.ready.
// Reset empties the queue, marks every store entry as zero, clears the dirty
// and busy flags and the last flush time, and loads the register defaults.
// ----------------------------------------------------------------------------
module led_strip_pixel_frame_formatter import ledf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ledf_item_if.sink   items,
	ledf_result_if.source results,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [1:0]        chip_q;
	logic [CountW-1:0] count_q;
	logic [31:0]       quiet_q;
	logic [CountW-1:0] len;

	logic push;
	logic full;
	logic pop;
	logic head_vld;
	cmd_t cmd;
	cmd_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_q  <= CHIP_GRB;
			count_q <= MAX_LEN;
			quiet_q <= 32'd1000000;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CHIP:  chip_q  <= cfg_data[1:0];
				REG_COUNT: count_q <= cfg_data[CountW-1:0];
				REG_QUIET: quiet_q <= cfg_data;
				default:   chip_q  <= chip_q;
			endcase
		end
	end

	assign len = live_len(count_q);

	ledf_front u_front (
		.items (items),
		.full  (full),
		.len   (len),
		.push  (push),
		.cmd   (cmd)
	);

	ledf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.head_vld  (head_vld)
	);

	ledf_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.head_vld        (head_vld),
		.pop             (pop),
		.chip_type       (chip_q),
		.len             (len),
		.quiescent_limit (quiet_q),
		.results         (results)
	);

endmodule
